// ----- rtl/cmfta_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers of the cube map face and texel address block
// no dependencies

package cmfta_pkg;

  localparam int MAX_FACE_SIDE = 4096;
  localparam int FRACTION_BITS = 8;

  localparam int SIDE_W  = $clog2(MAX_FACE_SIDE);     // bits of (side - 1)
  localparam int SCALE_W = SIDE_W + FRACTION_BITS;    // bits of scale factor and quotient
  localparam int COORD_W = 20;
  localparam int NUMER_W = 33;                        // numerator in [0, 2M]
  localparam int PROD_W  = NUMER_W + SCALE_W;         // numerator times scale

  localparam logic [2:0] FACE_RIGHT = 3'd0;
  localparam logic [2:0] FACE_LEFT  = 3'd1;
  localparam logic [2:0] FACE_UP    = 3'd2;
  localparam logic [2:0] FACE_DOWN  = 3'd3;
  localparam logic [2:0] FACE_FRONT = 3'd4;
  localparam logic [2:0] FACE_BACK  = 3'd5;

  localparam logic [2:0] REG_ANCHOR_X    = 3'd0;
  localparam logic [2:0] REG_ANCHOR_Y    = 3'd1;
  localparam logic [2:0] REG_ANCHOR_Z    = 3'd2;
  localparam logic [2:0] REG_FACE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_FACE_HEIGHT = 3'd4;

  localparam logic [12:0] SIDE_RESET = 13'd256;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         face_index;
    logic [COORD_W-1:0] u_coord;
    logic [COORD_W-1:0] v_coord;
    logic               degenerate;
  } out_item_t;

  // saturating 32-bit difference
  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

  // scale factor (clamped side - 1) with the fraction bits appended
  function automatic logic [SCALE_W-1:0] side_scale(logic [12:0] s);
    logic [SIDE_W-1:0] m1;
    if (s == 13'd0) begin
      m1 = '0;
    end else if (32'(s) > MAX_FACE_SIDE) begin
      m1 = SIDE_W'(MAX_FACE_SIDE - 1);
    end else begin
      m1 = SIDE_W'(s - 13'd1);
    end
    side_scale = {m1, {FRACTION_BITS{1'b0}}};
  endfunction

  // quotient to coordinate field, all ones when it does not fit
  function automatic logic [COORD_W-1:0] sat_coord(logic [SCALE_W-1:0] q);
    if (SCALE_W > COORD_W && (64'(q) >> COORD_W) != 64'd0) begin
      sat_coord = '1;
    end else begin
      sat_coord = COORD_W'(q);
    end
  endfunction

endpackage

// ----- rtl/cube_map_face_and_texel_address.sv -----
`timescale 1ns / 1ps
// cube map face select and texel address: anchor subtract, major axis pick,
// multiply by face scale and a one-bit-per-stage restoring divider; uses cmfta_pkg
//
// registered path from input transaction to result: 2 front stages, multiply,
//   one divider stage per quotient bit, output register
// throughput: one transaction per cycle; the whole pipe holds while a result is not taken
// reset: synchronous active-low rst_n clears valid bits and loads the register reset values

module cube_map_face_and_texel_address (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmfta_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cmfta_pkg::out_item_t  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int QW = cmfta_pkg::SCALE_W;
  localparam int NW = cmfta_pkg::PROD_W;

  // configuration
  logic signed [31:0] anchor_x_r, anchor_y_r, anchor_z_r;
  logic [12:0]        face_width_r, face_height_r;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r    <= '0;
      anchor_y_r    <= '0;
      anchor_z_r    <= '0;
      face_width_r  <= cmfta_pkg::SIDE_RESET;
      face_height_r <= cmfta_pkg::SIDE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cmfta_pkg::REG_ANCHOR_X:    anchor_x_r    <= cfg_pwdata;
        cmfta_pkg::REG_ANCHOR_Y:    anchor_y_r    <= cfg_pwdata;
        cmfta_pkg::REG_ANCHOR_Z:    anchor_z_r    <= cfg_pwdata;
        cmfta_pkg::REG_FACE_WIDTH:  face_width_r  <= cfg_pwdata[12:0];
        cmfta_pkg::REG_FACE_HEIGHT: face_height_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cmfta_pkg::REG_ANCHOR_X:    cfg_prdata = anchor_x_r;
      cmfta_pkg::REG_ANCHOR_Y:    cfg_prdata = anchor_y_r;
      cmfta_pkg::REG_ANCHOR_Z:    cfg_prdata = anchor_z_r;
      cmfta_pkg::REG_FACE_WIDTH:  cfg_prdata = {19'd0, face_width_r};
      cmfta_pkg::REG_FACE_HEIGHT: cfg_prdata = {19'd0, face_height_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // pipeline advance: everything moves unless the output holds an untaken result
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: saturated difference
  logic               s1_vld_r;
  logic signed [31:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= cmfta_pkg::sat_sub(in_data.point_x, anchor_x_r);
      dy_r <= cmfta_pkg::sat_sub(in_data.point_y, anchor_y_r);
      dz_r <= cmfta_pkg::sat_sub(in_data.point_z, anchor_z_r);
    end
  end

  // stage 2: major axis, face and numerators
  logic [31:0]        ax, ay, az, mag;
  logic [2:0]         face_nxt;
  logic signed [33:0] sm, nu_nxt, nv_nxt;

  assign ax = dx_r[31] ? 32'(-dx_r) : 32'(dx_r);
  assign ay = dy_r[31] ? 32'(-dy_r) : 32'(dy_r);
  assign az = dz_r[31] ? 32'(-dz_r) : 32'(dz_r);

  always_comb begin
    priority if (ax >= ay && ax >= az) begin
      mag      = ax;
      sm       = {2'b00, ax};
      face_nxt = (!dx_r[31] && dx_r != 0) ? cmfta_pkg::FACE_RIGHT : cmfta_pkg::FACE_LEFT;
      nu_nxt   = sm - 34'(dz_r);
      nv_nxt   = sm - 34'(dy_r);
    end else if (ay >= az) begin
      mag      = ay;
      sm       = {2'b00, ay};
      face_nxt = (!dy_r[31] && dy_r != 0) ? cmfta_pkg::FACE_UP : cmfta_pkg::FACE_DOWN;
      nu_nxt   = sm + 34'(dx_r);
      nv_nxt   = sm + 34'(dz_r);
    end else begin
      mag      = az;
      sm       = {2'b00, az};
      face_nxt = (!dz_r[31] && dz_r != 0) ? cmfta_pkg::FACE_FRONT : cmfta_pkg::FACE_BACK;
      nu_nxt   = sm - 34'(dx_r);
      nv_nxt   = sm - 34'(dy_r);
    end
  end

  logic                             s2_vld_r;
  logic [cmfta_pkg::NUMER_W-1:0]    nu_r, nv_r, s2_den_r;
  logic [2:0]                       s2_face_r;
  logic                             s2_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nu_r      <= nu_nxt[cmfta_pkg::NUMER_W-1:0];
      nv_r      <= nv_nxt[cmfta_pkg::NUMER_W-1:0];
      s2_den_r  <= {mag, 1'b0};
      s2_face_r <= face_nxt;
      s2_deg_r  <= (mag == 32'd0);
    end
  end

  // stage 3: numerator times scale feeds divider stage 0
  logic            dv_vld_r  [QW+1];
  logic [NW-1:0]   rem_u_r   [QW+1];
  logic [NW-1:0]   rem_v_r   [QW+1];
  logic [QW-1:0]   q_u_r     [QW+1];
  logic [QW-1:0]   q_v_r     [QW+1];
  logic [cmfta_pkg::NUMER_W-1:0] den_r [QW+1];
  logic [2:0]      face_r    [QW+1];
  logic            deg_r     [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_u_r[0] <= NW'(nu_r) * NW'(cmfta_pkg::side_scale(face_width_r));
      rem_v_r[0] <= NW'(nv_r) * NW'(cmfta_pkg::side_scale(face_height_r));
      q_u_r[0]   <= '0;
      q_v_r[0]   <= '0;
      den_r[0]   <= s2_den_r;
      face_r[0]  <= s2_face_r;
      deg_r[0]   <= s2_deg_r;
    end
  end

  // restoring divider, one quotient bit per stage, msb first;
  // the quotient never exceeds the scale since the numerator is at most 2M
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int B = QW - 1 - s;
    logic [NW-1:0] trial;
    logic          take_u, take_v;

    assign trial  = NW'(den_r[s]) << B;
    assign take_u = rem_u_r[s] >= trial;
    assign take_v = rem_v_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_u_r[s+1]  <= take_u ? rem_u_r[s] - trial : rem_u_r[s];
        rem_v_r[s+1]  <= take_v ? rem_v_r[s] - trial : rem_v_r[s];
        q_u_r[s+1]    <= q_u_r[s] | (QW'(take_u) << B);
        q_v_r[s+1]    <= q_v_r[s] | (QW'(take_v) << B);
        den_r[s+1]    <= den_r[s];
        face_r[s+1]   <= face_r[s];
        deg_r[s+1]    <= deg_r[s];
      end
    end
  end

  // output register
  logic                 out_valid_r;
  cmfta_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.degenerate <= deg_r[QW];
      out_data_r.face_index <= deg_r[QW] ? cmfta_pkg::FACE_RIGHT : face_r[QW];
      out_data_r.u_coord    <= deg_r[QW] ? '0 : cmfta_pkg::sat_coord(q_u_r[QW]);
      out_data_r.v_coord    <= deg_r[QW] ? '0 : cmfta_pkg::sat_coord(q_v_r[QW]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.u_coord == '0 && out_data.v_coord == '0 &&
      out_data.face_index == cmfta_pkg::FACE_RIGHT)
    else $error("degenerate result with nonzero fields");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.face_index <= cmfta_pkg::FACE_BACK)
    else $error("face index out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_vld_r)
    else $error("accepted transaction lost at entry");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QW] && !adv |=> dv_vld_r[QW])
    else $error("divider output dropped during stall");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for cube_map_face_and_texel_address: random and directed points
// against an in-bench face and texel address predictor; needs rtl/cmfta_pkg.sv and the dut

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cmfta_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cmfta_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cube_map_face_and_texel_address dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic signed [31:0] anc_x, anc_y, anc_z;
  logic [12:0] side_w, side_h;

  cmfta_pkg::in_item_t point_q[$];
  cmfta_pkg::out_item_t texel_q[$];
  int fail_cnt = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;
  bit long_stall = 1'b0;

  function automatic logic signed [31:0] clip_diff(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d > 64'sd2147483647) return 32'sh7fffffff;
    if (d < -64'sd2147483648) return 32'sh80000000;
    return d[31:0];
  endfunction

  function automatic logic [19:0] texel_coord(longint n, longint m, logic [12:0] s);
    longint sd, q;
    sd = (s == 0) ? 1 : (s > cmfta_pkg::MAX_FACE_SIDE ? longint'(cmfta_pkg::MAX_FACE_SIDE)
                                                      : longint'(s));
    q = (n * (sd - 1) * (longint'(1) << cmfta_pkg::FRACTION_BITS)) / (2 * m);
    return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  function automatic cmfta_pkg::out_item_t predict_texel(cmfta_pkg::in_item_t p);
    cmfta_pkg::out_item_t r;
    longint dx, dy, dz, ax, ay, az, m, nu, nv;
    dx = clip_diff(p.point_x, anc_x);
    dy = clip_diff(p.point_y, anc_y);
    dz = clip_diff(p.point_z, anc_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    if (ax >= ay && ax >= az) begin
      m = ax; r.face_index = dx > 0 ? cmfta_pkg::FACE_RIGHT : cmfta_pkg::FACE_LEFT;
      nu = m - dz; nv = m - dy;
    end else if (ay >= az) begin
      m = ay; r.face_index = dy > 0 ? cmfta_pkg::FACE_UP : cmfta_pkg::FACE_DOWN;
      nu = m + dx; nv = m + dz;
    end else begin
      m = az; r.face_index = dz > 0 ? cmfta_pkg::FACE_FRONT : cmfta_pkg::FACE_BACK;
      nu = m - dx; nv = m - dy;
    end
    r.u_coord = texel_coord(nu, m, side_w);
    r.v_coord = texel_coord(nv, m, side_h);
    return r;
  endfunction

  // ready sampled at the rising edge, so the driver knows whether the transaction went
  logic in_ready_s = 1'b0;
  always @(posedge clk) in_ready_s <= in_ready;

  // driver: bursts and gaps, fed from point_q
  int gap_left = 0, burst_left = 0;
  always @(negedge clk) begin
    if (!(in_valid && !in_ready_s)) begin
      if (point_q.size() > 0 && !hold_sender && gap_left == 0) begin
        in_data <= point_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : 1000;
          gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern plus an occasional long hold-off
  int stall_phase = 0, stall_mode = 0, long_cnt = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (long_stall && long_cnt < 200) begin
      long_cnt++;
      out_ready <= 1'b0;
    end else begin
      if (stall_phase % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_phase % 5) != 0;
        default: out_ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    cmfta_pkg::out_item_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        texel_q.push_back(predict_texel(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_cnt++;
        end else begin
          e = texel_q.pop_front();
          if (out_data.face_index !== e.face_index) begin
            $error("face_index exp %0d got %0d", e.face_index, out_data.face_index);
            fail_cnt++;
          end
          if (out_data.u_coord !== e.u_coord) begin
            $error("u_coord exp %0d got %0d", e.u_coord, out_data.u_coord);
            fail_cnt++;
          end
          if (out_data.v_coord !== e.v_coord) begin
            $error("v_coord exp %0d got %0d", e.v_coord, out_data.v_coord);
            fail_cnt++;
          end
          if (out_data.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, out_data.degenerate);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("cube_map_face_and_texel_address verification failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      cmfta_pkg::REG_ANCHOR_X: anc_x = val;
      cmfta_pkg::REG_ANCHOR_Y: anc_y = val;
      cmfta_pkg::REG_ANCHOR_Z: anc_z = val;
      cmfta_pkg::REG_FACE_WIDTH: side_w = val[12:0];
      cmfta_pkg::REG_FACE_HEIGHT: side_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (point_q.size() > 0 || in_valid || texel_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic drain_all_except_held();
    while (in_valid || texel_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 8) - 4;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      4: return $urandom_range(0, 7) << $urandom_range(0, 30);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cmfta_pkg::in_item_t p;
    p.point_x = x; p.point_y = y; p.point_z = z;
    point_q.push_back(p);
  endtask

  task automatic random_points(int n);
    logic [31:0] a;
    repeat (n) begin
      a = rand_coord();
      // some ties on purpose
      case ($urandom_range(0, 5))
        0: push_point(a, a, rand_coord());
        1: push_point(a, rand_coord(), -a);
        2: push_point(rand_coord(), a, a);
        default: push_point(rand_coord(), rand_coord(), rand_coord());
      endcase
    end
  endtask

  initial begin
    anc_x = 0; anc_y = 0; anc_z = 0;
    side_w = cmfta_pkg::SIDE_RESET; side_h = cmfta_pkg::SIDE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed at reset settings: each face, ties, zero, extremes
    push_point(0, 0, 0);
    push_point(32'h10000, 0, 0);
    push_point(-32'sh10000, 32'h8000, 32'h4000);
    push_point(32'h100, 32'h200, -32'sh80);
    push_point(32'h100, -32'sh200, 32'h80);
    push_point(32'h10, 32'h20, 32'h30);
    push_point(32'h10, -32'sh20, -32'sh30);
    push_point(32'h50, 32'h50, 32'h50);
    push_point(-32'sh50, 32'h50, 32'h50);
    push_point(32'h10, 32'h50, -32'sh50);
    push_point(32'h80000000, 32'h80000000, 32'h80000000);
    push_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_point(32'hffffffff, 32'h1, 32'h0);
    drain_all();

    // saturation with extreme anchors, extreme sizes
    reg_write(cmfta_pkg::REG_ANCHOR_X, 32'h80000000);
    reg_write(cmfta_pkg::REG_ANCHOR_Y, 32'h7fffffff);
    reg_write(cmfta_pkg::REG_ANCHOR_Z, 32'h00010000);
    reg_write(cmfta_pkg::REG_FACE_WIDTH, 32'd4096);
    reg_write(cmfta_pkg::REG_FACE_HEIGHT, 32'd1);
    push_point(32'h7fffffff, 32'h80000000, 32'h0);
    push_point(32'h80000000, 32'h7fffffff, 32'h00010000);
    push_point(32'h0, 32'h0, 32'h0);
    random_points(300);
    drain_all();

    reg_write(cmfta_pkg::REG_FACE_WIDTH, 32'd0);
    reg_write(cmfta_pkg::REG_FACE_HEIGHT, 32'h1fff);
    reg_write(cmfta_pkg::REG_ANCHOR_X, 32'h0);
    reg_write(cmfta_pkg::REG_ANCHOR_Y, 32'h0);
    reg_write(cmfta_pkg::REG_ANCHOR_Z, 32'h80000000);
    random_points(300);
    // receiver holds off while the sender keeps offering
    long_stall = 1'b1;
    drain_all();

    // sender pause until everything is back
    hold_sender = 1'b1;
    random_points(200);
    drain_all_except_held();
    hold_sender = 1'b0;
    drain_all();

    repeat (3) begin
      reg_write(cmfta_pkg::REG_ANCHOR_X, $urandom);
      reg_write(cmfta_pkg::REG_ANCHOR_Y, $urandom_range(0, 255) << 12);
      reg_write(cmfta_pkg::REG_ANCHOR_Z, $urandom);
      reg_write(cmfta_pkg::REG_FACE_WIDTH, $urandom_range(1, 4096));
      reg_write(cmfta_pkg::REG_FACE_HEIGHT, $urandom_range(1, 8191));
      random_points(300);
      drain_all();
    end

    if (fail_cnt == 0) begin
      $display("cube_map_face_and_texel_address verification clean");
    end else begin
      $display("cube_map_face_and_texel_address verification failed");
    end
    $finish;
  end

endmodule
